>>> rtl/operator_symbol_tokenizer_unit_defines.svh
// Assertion macros for the operator symbol tokenizer checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef OPERATOR_SYMBOL_TOKENIZER_UNIT_DEFINES_SVH
`define OPERATOR_SYMBOL_TOKENIZER_UNIT_DEFINES_SVH

// Implication checked out of reset only.
`define OST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define OST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ost_pkg.sv
// Package for the operator symbol tokenizer: token codes, character codes,
// pair type and the classify/merge functions. No dependencies.
`default_nettype none

package ost_pkg;

  localparam int unsigned KIND_W = 6;
  localparam int unsigned PEND_W = 4;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_DOT       = 6'd0;
  localparam logic [KIND_W-1:0] KIND_COLON     = 6'd1;
  localparam logic [KIND_W-1:0] KIND_SEMI      = 6'd2;
  localparam logic [KIND_W-1:0] KIND_LPAREN    = 6'd3;
  localparam logic [KIND_W-1:0] KIND_RPAREN    = 6'd4;
  localparam logic [KIND_W-1:0] KIND_LBRACK    = 6'd5;
  localparam logic [KIND_W-1:0] KIND_RBRACK    = 6'd6;
  localparam logic [KIND_W-1:0] KIND_LBRACE    = 6'd7;
  localparam logic [KIND_W-1:0] KIND_RBRACE    = 6'd8;
  localparam logic [KIND_W-1:0] KIND_LT        = 6'd9;
  localparam logic [KIND_W-1:0] KIND_GT        = 6'd10;
  localparam logic [KIND_W-1:0] KIND_ASSIGN    = 6'd11;
  localparam logic [KIND_W-1:0] KIND_PIPE      = 6'd12;
  localparam logic [KIND_W-1:0] KIND_AMP       = 6'd13;
  localparam logic [KIND_W-1:0] KIND_CARET     = 6'd14;
  localparam logic [KIND_W-1:0] KIND_PLUS      = 6'd15;
  localparam logic [KIND_W-1:0] KIND_MINUS     = 6'd16;
  localparam logic [KIND_W-1:0] KIND_STAR      = 6'd17;
  localparam logic [KIND_W-1:0] KIND_SLASH     = 6'd18;
  localparam logic [KIND_W-1:0] KIND_LE        = 6'd19;
  localparam logic [KIND_W-1:0] KIND_GE        = 6'd20;
  localparam logic [KIND_W-1:0] KIND_EQ        = 6'd21;
  localparam logic [KIND_W-1:0] KIND_OROR      = 6'd22;
  localparam logic [KIND_W-1:0] KIND_OR_EQ     = 6'd23;
  localparam logic [KIND_W-1:0] KIND_ANDAND    = 6'd24;
  localparam logic [KIND_W-1:0] KIND_AND_EQ    = 6'd25;
  localparam logic [KIND_W-1:0] KIND_XOR_EQ    = 6'd26;
  localparam logic [KIND_W-1:0] KIND_INC       = 6'd27;
  localparam logic [KIND_W-1:0] KIND_ADD_EQ    = 6'd28;
  localparam logic [KIND_W-1:0] KIND_DEC       = 6'd29;
  localparam logic [KIND_W-1:0] KIND_SUB_EQ    = 6'd30;
  localparam logic [KIND_W-1:0] KIND_ARROW     = 6'd31;
  localparam logic [KIND_W-1:0] KIND_MUL_EQ    = 6'd32;
  localparam logic [KIND_W-1:0] KIND_DIV_EQ    = 6'd33;
  localparam logic [KIND_W-1:0] KIND_LINE_CMT  = 6'd34;
  localparam logic [KIND_W-1:0] KIND_BLOCK_CMT = 6'd35;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 6'd36;

  localparam logic [KIND_W-1:0] PREFIX_OFFSET  = 6'd8;
  localparam logic [PEND_W-1:0] PEND_NONE      = 4'd0;
  localparam logic [PEND_W-1:0] PEND_LAST      = 4'd10;

  // Character codes
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  // One queue entry: one or two tokens caused by the same character
  typedef struct packed {
    logic              two;
    logic [KIND_W-1:0] k0;
    logic [KIND_W-1:0] k1;
  } pair_t;

  // Decoder result handed to the top level
  typedef struct packed {
    logic              push;
    pair_t             pair;
    logic [PEND_W-1:0] pend_nxt;
  } dec_t;

  function automatic logic [KIND_W-1:0] classify(input logic [7:0] ch);
    logic [KIND_W-1:0] k;
    unique case (ch)
      CH_DOT:    k = KIND_DOT;
      CH_COLON:  k = KIND_COLON;
      CH_SEMI:   k = KIND_SEMI;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LT:     k = KIND_LT;
      CH_GT:     k = KIND_GT;
      CH_EQ:     k = KIND_ASSIGN;
      CH_PIPE:   k = KIND_PIPE;
      CH_AMP:    k = KIND_AMP;
      CH_CARET:  k = KIND_CARET;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      default:   k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Returns {hit, kind}; hit low means the pair does not form an operator
  function automatic logic [KIND_W:0] merge(input logic [KIND_W-1:0] held,
                                            input logic [7:0] ch);
    logic              hit;
    logic [KIND_W-1:0] k;
    hit = 1'b0;
    k   = KIND_ERROR;
    unique case (held)
      KIND_LT:     begin hit = (ch == CH_EQ); k = KIND_LE; end
      KIND_GT:     begin hit = (ch == CH_EQ); k = KIND_GE; end
      KIND_ASSIGN: begin hit = (ch == CH_EQ); k = KIND_EQ; end
      KIND_PIPE: begin
        hit = (ch == CH_PIPE) || (ch == CH_EQ);
        k   = (ch == CH_PIPE) ? KIND_OROR : KIND_OR_EQ;
      end
      KIND_AMP: begin
        hit = (ch == CH_AMP) || (ch == CH_EQ);
        k   = (ch == CH_AMP) ? KIND_ANDAND : KIND_AND_EQ;
      end
      KIND_CARET:  begin hit = (ch == CH_EQ); k = KIND_XOR_EQ; end
      KIND_PLUS: begin
        hit = (ch == CH_PLUS) || (ch == CH_EQ);
        k   = (ch == CH_PLUS) ? KIND_INC : KIND_ADD_EQ;
      end
      KIND_MINUS: begin
        hit = (ch == CH_MINUS) || (ch == CH_EQ) || (ch == CH_GT);
        k   = (ch == CH_MINUS) ? KIND_DEC : ((ch == CH_EQ) ? KIND_SUB_EQ : KIND_ARROW);
      end
      KIND_STAR:   begin hit = (ch == CH_EQ); k = KIND_MUL_EQ; end
      KIND_SLASH: begin
        hit = (ch == CH_SLASH) || (ch == CH_STAR) || (ch == CH_EQ);
        k   = (ch == CH_SLASH) ? KIND_LINE_CMT :
              ((ch == CH_STAR) ? KIND_BLOCK_CMT : KIND_DIV_EQ);
      end
      default: begin hit = 1'b0; k = KIND_ERROR; end
    endcase
    return {hit, k};
  endfunction

endpackage

`default_nettype wire

>>> rtl/ost_decode.sv
// Token decoder: one character plus the held prefix in, up to two tokens
// and the next held prefix out. Depends on ost_pkg.
`default_nettype none

module ost_decode (
  input  wire logic [7:0]                   char_code,
  input  wire logic                         end_of_input,
  input  wire logic [ost_pkg::PEND_W-1:0]   pend,
  output ost_pkg::dec_t                     dec
);
  import ost_pkg::*;

  logic              held_vld;
  logic [KIND_W-1:0] held;
  logic [KIND_W:0]   mrg;
  logic [KIND_W-1:0] cls;
  logic              cls_prefix;

  assign held_vld   = (pend != PEND_NONE) && (pend <= PEND_LAST);
  assign held       = {{(KIND_W-PEND_W){1'b0}}, pend} + PREFIX_OFFSET;
  assign mrg        = merge(held, char_code);
  assign cls        = classify(char_code);
  assign cls_prefix = (cls >= KIND_LT) && (cls <= KIND_SLASH);

  always_comb begin
    dec          = '0;
    dec.pend_nxt = PEND_NONE;
    if (held_vld) begin
      dec.push    = 1'b1;
      dec.pair.k0 = mrg[KIND_W] ? mrg[KIND_W-1:0] : held;
    end
    if (!(held_vld && mrg[KIND_W])) begin
      if (cls_prefix && !end_of_input) begin
        // hold the prefix for one character of lookahead
        dec.pend_nxt = PEND_W'(cls - PREFIX_OFFSET);
      end else if (held_vld) begin
        dec.pair.two = 1'b1;
        dec.pair.k1  = cls;
      end else begin
        dec.push    = 1'b1;
        dec.pair.k0 = cls;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ost_token_queue.sv
// Two-entry result queue of token pairs with a token-wide output side.
// Depends on ost_pkg.
`default_nettype none

module ost_token_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire ost_pkg::pair_t             pair,
  output logic                            full,
  output logic                            tok_vld,
  input  wire logic                       tok_rdy,
  output logic [ost_pkg::KIND_W-1:0]      tok_kind,
  output logic                            tok_last
);
  import ost_pkg::*;

  pair_t      ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;
  pair_t      head;
  logic       pop_tok, pop_ent;

  assign head     = ent_r[rd_ptr_r];
  assign full     = (cnt_r == 2'd2);
  assign tok_vld  = (cnt_r != 2'd0);
  assign tok_kind = sel_r ? head.k1 : head.k0;
  assign tok_last = sel_r || !head.two;
  assign pop_tok  = tok_vld && tok_rdy;
  // retire the entry once its final token has gone
  assign pop_ent  = pop_tok && (sel_r || !head.two);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ent ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop_ent};
    sel_nxt    = pop_tok ? !pop_ent : sel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      sel_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      sel_r    <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= pair;
    end
  end

endmodule

`default_nettype wire

>>> rtl/operator_symbol_tokenizer_unit.sv
// Path: a taken character waits in the input register, is decoded from there and, unless
// held as a prefix, is written into the token queue once it has room for the pair.
// Throughput: one character per cycle while each yields at most one token and out_tready
// stays high; a character that flushes a held prefix and adds its own token yields two.
// Reset (rst_n low, synchronous) drops the input register, the held prefix and the queue.
`default_nettype none

module operator_symbol_tokenizer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_code
  input  wire logic       in_tlast,   // end_of_input
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [5:0] token_kind, [7:6] zero
  output logic            out_tlast   // last_of_run
);
  import ost_pkg::*;

  // Input register: one character waiting for the decoder
  logic              in_v_r, in_v_nxt;
  logic [7:0]        char_r;
  logic              eoi_r;
  // Held prefix (0 means nothing held)
  logic [PEND_W-1:0] pend_r, pend_nxt;

  dec_t              dec;
  logic              q_full;
  logic              adv;
  logic              in_xfer;
  logic [KIND_W-1:0] tok_kind;

  // Advance the held character into the queue whenever there is room for its pair
  assign adv       = in_v_r && !q_full;
  assign in_tready = !in_v_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_v_nxt = in_xfer ? 1'b1 : (adv ? 1'b0 : in_v_r);
    pend_nxt = adv ? dec.pend_nxt : pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      pend_r <= PEND_NONE;
    end else begin
      in_v_r <= in_v_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Payload needs no reset: hold it on every input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_r <= in_tdata;
      eoi_r  <= in_tlast;
    end
  end

  ost_decode u_decode (
    .char_code    (char_r),
    .end_of_input (eoi_r),
    .pend         (pend_r),
    .dec          (dec)
  );

  ost_token_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (adv && dec.push),
    .pair     (dec.pair),
    .full     (q_full),
    .tok_vld  (out_tvalid),
    .tok_rdy  (out_tready),
    .tok_kind (tok_kind),
    .tok_last (out_tlast)
  );

  assign out_tdata = {2'b00, tok_kind};

endmodule

`default_nettype wire

>>> rtl/ost_checker.sv
// Port-level checker for operator_symbol_tokenizer_unit, with its bind.
// Depends on ost_pkg and operator_symbol_tokenizer_unit_defines.svh.
`default_nettype none
`include "operator_symbol_tokenizer_unit_defines.svh"

module ost_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);
  import ost_pkg::*;

  `OST_ASSERT_IMPL(a_kind_range, out_tvalid, out_tdata[5:0] <= KIND_ERROR, "token kind out of range")
  `OST_ASSERT_IMPL(a_pad_zero, out_tvalid, out_tdata[7:6] == 2'b00, "tdata padding not zero")
  `OST_ASSERT_NEXT(a_reset_idle, !rst_n, !out_tvalid, "result offered after reset")
  `OST_ASSERT_IMPL(a_stall_hold, $past(out_tvalid && !out_tready) && rst_n && $past(rst_n), out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `OST_ASSERT_NEXT(a_ready_after_reset, !rst_n, in_tready, "input not ready after reset")

endmodule

bind operator_symbol_tokenizer_unit ost_checker u_ost_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
